[rtl/core/deterministic_primality_test_32_defines.svh]
// Assertion macros used by the checker file of the primality tester.
// The enclosing module must provide i_clk and i_rst_n.
`ifndef DETERMINISTIC_PRIMALITY_TEST_32_DEFINES_SVH
`define DETERMINISTIC_PRIMALITY_TEST_32_DEFINES_SVH

// Implication that is checked only outside reset.
`define DPT_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked outside reset.
`define DPT_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is also checked across reset.
`define DPT_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[rtl/core/dpt32_pkg.sv]
// ----------------------------------------------------------------------------
// dpt32_pkg
// Types and constants shared by the primality tester modules.
// ----------------------------------------------------------------------------
`default_nettype none

package dpt32_pkg;

    // Classification of one item, made by the front end.
    typedef struct packed {
        logic trivial;   // answered without any witness round
        logic tval;      // answer for trivial items
        logic need7;     // base-7 round applies
        logic need61;    // base-61 round applies
    } t_class;

    // Witness bases; all fit in six bits.
    localparam int          BASE_BITS = 6;
    localparam logic [5:0] WITNESS_A = 6'd2;
    localparam logic [5:0] WITNESS_B = 6'd7;
    localparam logic [5:0] WITNESS_C = 6'd61;

    typedef enum logic [2:0] {
        R_BASE2  = 3'b001,
        R_BASE7  = 3'b010,
        R_BASE61 = 3'b100
    } t_round;

    typedef enum logic [6:0] {
        S_IDLE   = 7'b0000001,
        S_DECOMP = 7'b0000010,
        S_PSTEP  = 7'b0000100,
        S_PSQ_W  = 7'b0001000,
        S_PMUL_W = 7'b0010000,
        S_CHK    = 7'b0100000,
        S_SQR_W  = 7'b1000000
    } t_state;

endpackage

`default_nettype wire

[rtl/core/dpt32_front.sv]
// ----------------------------------------------------------------------------
// dpt32_front
// Accepts items, classifies them and holds them in a two-entry queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt32_front #(
    parameter int W = 32
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  logic [W-1:0]    i_candidate,
    output logic            o_full,
    input  logic            i_take,
    output logic            o_valid,
    output logic [W-1:0]    o_n,
    output dpt32_pkg::t_class o_cls
);
    import dpt32_pkg::*;

    logic [W-1:0] r_n_q [2];
    t_class       r_c_q [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;
    t_class       w_cls;
    logic         w_push_ok;
    logic         w_take_ok;

    always_comb begin
        w_cls.tval    = (i_candidate == W'(2));
        // Even numbers and one are settled here; two is the prime among them.
        w_cls.trivial = !i_candidate[0] || (i_candidate == W'(1));
        w_cls.need7   = (i_candidate > W'(7));
        w_cls.need61  = (i_candidate > W'(61));
    end

    assign o_full    = (r_cnt == 2'd2);
    assign o_valid   = (r_cnt != 2'd0);
    assign w_push_ok = i_push && !o_full;
    assign w_take_ok = i_take && o_valid;
    assign o_n       = r_n_q[r_rp];
    assign o_cls     = r_c_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_n_q[r_wp] <= i_candidate;
            r_c_q[r_wp] <= w_cls;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push_ok) r_wp <= !r_wp;
            if (w_take_ok) r_rp <= !r_rp;
            r_cnt <= r_cnt + {1'b0, w_push_ok} - {1'b0, w_take_ok};
        end
    end

endmodule

`default_nettype wire

[rtl/core/dpt32_mulmod.sv]
// ----------------------------------------------------------------------------
// dpt32_mulmod
// Bit-serial modular multiplier: x*y mod m, one bit of y per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt32_mulmod #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic [W-1:0]         i_x,
    input  logic [W-1:0]         i_y,
    input  logic [W-1:0]         i_m,
    input  logic [$clog2(W)-1:0] i_top,
    output logic                 o_done,
    output logic [W-1:0]         o_res
);
    logic                 r_busy;
    logic                 r_done;
    logic [$clog2(W)-1:0] r_idx;
    logic [W-1:0]         r_acc;
    logic [W-1:0]         r_x;
    logic [W-1:0]         r_y;
    logic [W-1:0]         r_m;
    logic [W:0]           w_dbl;
    logic [W:0]           w_dred;
    logic [W:0]           w_sum;
    logic [W:0]           w_sred;

    // Both operands stay below m, so each partial result needs one subtract.
    always_comb begin
        w_dbl  = {r_acc, 1'b0};
        w_dred = (w_dbl >= {1'b0, r_m}) ? (w_dbl - {1'b0, r_m}) : w_dbl;
        w_sum  = w_dred + (r_y[r_idx] ? {1'b0, r_x} : {(W+1){1'b0}});
        w_sred = (w_sum >= {1'b0, r_m}) ? (w_sum - {1'b0, r_m}) : w_sum;
    end

    assign o_done = r_done;
    assign o_res  = r_acc;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_y   <= i_y;
            r_m   <= i_m;
            r_idx <= i_top;
            r_acc <= '0;
        end else if (r_busy) begin
            r_acc <= w_sred[W-1:0];
            if (r_idx != '0) r_idx <= r_idx - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && (r_idx == '0)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

[rtl/core/dpt32_engine.sv]
// ----------------------------------------------------------------------------
// dpt32_engine
// Runs the Miller-Rabin rounds of one item and holds its result.
// ----------------------------------------------------------------------------
`default_nettype none

module dpt32_engine #(
    parameter int W = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  logic [W-1:0]      i_job_n,
    input  dpt32_pkg::t_class i_job_cls,
    output logic              o_job_take,
    input  logic              i_pop,
    output logic              o_empty,
    output logic              o_flag
);
    import dpt32_pkg::*;

    localparam int IW = $clog2(W);

    t_state          r_state;
    t_round          r_round;
    logic [W-1:0]    r_n;
    logic [W-1:0]    r_d;
    logic [IW-1:0]   r_s;
    logic [IW-1:0]   r_k;
    logic [IW-1:0]   r_ebit;
    logic [W-1:0]    r_acc;
    logic            r_need7;
    logic            r_need61;
    logic            r_out_valid;
    logic            r_out_flag;
    logic            r_mstart;
    logic [W-1:0]    r_mx;
    logic [W-1:0]    r_my;
    logic [IW-1:0]   r_mtop;
    logic            w_mdone;
    logic [W-1:0]    w_mres;
    logic [W-1:0]    w_base;
    logic [W-1:0]    w_nm1;

    dpt32_mulmod #(.W(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mstart),
        .i_x     (r_mx),
        .i_y     (r_my),
        .i_m     (r_n),
        .i_top   (r_mtop),
        .o_done  (w_mdone),
        .o_res   (w_mres)
    );

    always_comb begin
        case (r_round)
            R_BASE2:  w_base = {{(W-BASE_BITS){1'b0}}, WITNESS_A};
            R_BASE7:  w_base = {{(W-BASE_BITS){1'b0}}, WITNESS_B};
            R_BASE61: w_base = {{(W-BASE_BITS){1'b0}}, WITNESS_C};
            default:  w_base = {{(W-BASE_BITS){1'b0}}, WITNESS_A};
        endcase
    end

    assign w_nm1      = r_n - W'(1);
    assign o_job_take = (r_state == S_IDLE) && i_job_valid && !r_out_valid;
    assign o_empty    = !r_out_valid;
    assign o_flag     = r_out_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_mstart    <= 1'b0;
        end else begin
            r_mstart <= 1'b0;
            if (i_pop && r_out_valid) r_out_valid <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (o_job_take) begin
                        if (i_job_cls.trivial) begin
                            r_out_valid <= 1'b1;
                            r_out_flag  <= i_job_cls.tval;
                        end else begin
                            r_n      <= i_job_n;
                            r_d      <= {1'b0, i_job_n[W-1:1]};
                            r_s      <= IW'(1);
                            r_round  <= R_BASE2;
                            r_need7  <= i_job_cls.need7;
                            r_need61 <= i_job_cls.need61;
                            r_state  <= S_DECOMP;
                        end
                    end
                end
                S_DECOMP: begin
                    if (!r_d[0]) begin
                        r_d <= {1'b0, r_d[W-1:1]};
                        r_s <= r_s + 1'b1;
                    end else begin
                        r_acc   <= W'(1);
                        r_ebit  <= IW'(W-1);
                        r_state <= S_PSTEP;
                    end
                end
                S_PSTEP: begin
                    // Squaring one gives one, so the leading zeros cost nothing.
                    if (r_acc == W'(1)) begin
                        if (r_d[r_ebit]) begin
                            r_mx     <= r_acc;
                            r_my     <= w_base;
                            r_mtop   <= IW'(BASE_BITS-1);
                            r_mstart <= 1'b1;
                            r_state  <= S_PMUL_W;
                        end else if (r_ebit == '0) begin
                            r_k     <= '0;
                            r_state <= S_CHK;
                        end else begin
                            r_ebit <= r_ebit - 1'b1;
                        end
                    end else begin
                        r_mx     <= r_acc;
                        r_my     <= r_acc;
                        r_mtop   <= IW'(W-1);
                        r_mstart <= 1'b1;
                        r_state  <= S_PSQ_W;
                    end
                end
                S_PSQ_W: begin
                    if (w_mdone) begin
                        r_acc <= w_mres;
                        if (r_d[r_ebit]) begin
                            r_mx     <= w_mres;
                            r_my     <= w_base;
                            r_mtop   <= IW'(BASE_BITS-1);
                            r_mstart <= 1'b1;
                            r_state  <= S_PMUL_W;
                        end else if (r_ebit == '0) begin
                            r_k     <= '0;
                            r_state <= S_CHK;
                        end else begin
                            r_ebit  <= r_ebit - 1'b1;
                            r_state <= S_PSTEP;
                        end
                    end
                end
                S_PMUL_W: begin
                    if (w_mdone) begin
                        r_acc <= w_mres;
                        if (r_ebit == '0) begin
                            r_k     <= '0;
                            r_state <= S_CHK;
                        end else begin
                            r_ebit  <= r_ebit - 1'b1;
                            r_state <= S_PSTEP;
                        end
                    end
                end
                S_CHK: begin
                    if (((r_k == '0) && (r_acc == W'(1))) ||
                        ((r_k != r_s) && (r_acc == w_nm1))) begin
                        // Round passed: move on to the next base that applies.
                        r_acc  <= W'(1);
                        r_ebit <= IW'(W-1);
                        if ((r_round == R_BASE2) && r_need7) begin
                            r_round <= R_BASE7;
                            r_state <= S_PSTEP;
                        end else if ((r_round != R_BASE61) && r_need61) begin
                            r_round <= R_BASE61;
                            r_state <= S_PSTEP;
                        end else begin
                            r_out_valid <= 1'b1;
                            r_out_flag  <= 1'b1;
                            r_state     <= S_IDLE;
                        end
                    end else if (r_k == r_s) begin
                        r_out_valid <= 1'b1;
                        r_out_flag  <= 1'b0;
                        r_state     <= S_IDLE;
                    end else begin
                        r_mx     <= r_acc;
                        r_my     <= r_acc;
                        r_mtop   <= IW'(W-1);
                        r_mstart <= 1'b1;
                        r_state  <= S_SQR_W;
                    end
                end
                S_SQR_W: begin
                    if (w_mdone) begin
                        r_acc   <= w_mres;
                        r_k     <= r_k + 1'b1;
                        r_state <= S_CHK;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

`default_nettype wire

[rtl/core/deterministic_primality_test_32.sv]
// ----------------------------------------------------------------------------
// deterministic_primality_test_32
// Deterministic Miller-Rabin primality test with bases 2, 7 and 61.
// ----------------------------------------------------------------------------
// Each item is one candidate of NUMBER_WIDTH bits; each gives one result
// flag, in order. Even numbers, zero and one are answered without any
// witness round. Odd candidates run up to three witness rounds on a
// bit-serial modular multiplier that steps through all NUMBER_WIDTH bits
// for a square and six bits for a multiply by a base. The squares of the
// exponentiation and of the check together stay below NUMBER_WIDTH per
// round. A two-entry queue in front and a result register behind let
// items be pushed while a test runs and while a result waits to be popped.
`default_nettype none

module deterministic_primality_test_32 #(
    parameter int NUMBER_WIDTH = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    push,
    input  logic [NUMBER_WIDTH-1:0] i_candidate,
    output logic                    full,
    output logic                    empty,
    input  logic                    pop,
    output logic                    o_is_prime_flag
);
    import dpt32_pkg::*;

    logic                    w_job_valid;
    logic                    w_job_take;
    logic [NUMBER_WIDTH-1:0] w_job_n;
    t_class                  w_job_cls;

    dpt32_front #(.W(NUMBER_WIDTH)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_candidate (i_candidate),
        .o_full      (full),
        .i_take      (w_job_take),
        .o_valid     (w_job_valid),
        .o_n         (w_job_n),
        .o_cls       (w_job_cls)
    );

    dpt32_engine #(.W(NUMBER_WIDTH)) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (w_job_valid),
        .i_job_n     (w_job_n),
        .i_job_cls   (w_job_cls),
        .o_job_take  (w_job_take),
        .i_pop       (pop),
        .o_empty     (empty),
        .o_flag      (o_is_prime_flag)
    );

endmodule

`default_nettype wire

[rtl/core/dpt32_checker.sv]
// ----------------------------------------------------------------------------
// dpt32_checker
// Port-level checks of the primality tester, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "deterministic_primality_test_32_defines.svh"

module dpt32_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_push,
    input logic i_full,
    input logic i_empty,
    input logic i_pop,
    input logic i_flag
);
    // Reset leaves no result pending and room for items.
    `DPT_ASSERT_RST(a_reset_clear, !i_rst_n, i_empty && !i_full)
    // The queue can only fill up through an accepted item.
    `DPT_ASSERT_IMPL(a_full_by_push, $rose(i_full), $past(i_push))
    // A waiting result is not lost or changed while it is not taken.
    `DPT_ASSERT_NEXT(a_result_holds, !i_empty && !i_pop, !i_empty && $stable(i_flag))

endmodule

bind deterministic_primality_test_32 dpt32_checker u_dpt32_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .i_push  (push),
    .i_full  (full),
    .i_empty (empty),
    .i_pop   (pop),
    .i_flag  (o_is_prime_flag)
);

`default_nettype wire
